### sv/env_image_checker_assert.svh
// assertion macros for the environment image checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ENV_IMAGE_CHECKER_ASSERT_SVH
`define ENV_IMAGE_CHECKER_ASSERT_SVH

// condition must hold in the same cycle
`define EIC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// trigger implies consequence in the next cycle
`define EIC_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

### sv/eic_pkg.sv
// shared types, constants and the byte-wide crc step for the image checker
// no dependencies
`default_nettype none

package eic_pkg;

  localparam int MAX_IMAGE_BYTES = 65536;
  localparam int MIN_IMAGE_BYTES = 6;
  localparam int HDR_BYTES       = 4;
  localparam int SIZE_W          = 17;
  localparam int OFS_W           = 16;
  localparam int CRC_W           = 32;
  localparam int SIZE_RESET      = 16384;

  localparam logic [7:0]       ASCII_EQ = 8'h3D;
  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;
  localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFFFFFF;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_WARN   = 1'b1;

  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 3;

  typedef enum logic [2:0] {
    EV_OK       = 3'd0,
    EV_NO_EQ    = 3'd1,
    EV_EMPTY    = 3'd2,
    EV_UNTERM   = 3'd3,
    EV_LIST_END = 3'd4,
    EV_CHECK    = 3'd5
  } event_kind_e;

  typedef enum logic [1:0] {
    CHK_OK    = 2'd0,
    CHK_WARN  = 2'd1,
    CHK_FATAL = 2'd2,
    CHK_SMALL = 2'd3
  } check_status_e;

  typedef enum logic [1:0] {
    MODE_AWAIT = 2'd0,
    MODE_ENTRY = 2'd1,
    MODE_DONE  = 2'd2
  } parse_mode_e;

  typedef enum logic [1:0] {
    CS_IDLE  = 2'd0,
    CS_PAD   = 2'd1,
    CS_CHECK = 2'd2
  } ctrl_state_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    event_kind_e      event_kind;
    logic [OFS_W-1:0] entry_begin;
    logic [OFS_W-1:0] equals_offset;
    logic [OFS_W-1:0] entry_finish;
    logic [CRC_W-1:0] stored_crc;
    logic [CRC_W-1:0] computed_crc;
    check_status_e    check_status;
    logic             size_mismatch;
    logic             run_last;
  } out_item_t;

  typedef struct packed {
    logic step;
    logic pad;
    logic close;
    logic check;
  } dp_cmd_t;

  typedef struct packed {
    logic too_small;
    logic pad_left;
    logic entry_open;
  } dp_sts_t;

  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [7:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {CRC_W{c[0]}});
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### sv/eic_out_fifo.sv
// four-entry result queue between the datapath and the output channel
// depends on eic_pkg
`default_nettype none

module eic_out_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  eic_pkg::out_item_t  push_data_i,
  input  logic                pop_i,
  output logic                valid_o,
  output eic_pkg::out_item_t  data_o,
  output logic                space_o,
  output logic                full_o
);
  import eic_pkg::*;

  out_item_t              mem_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   wr_q, wr_d;
  logic [OUT_PTR_W-1:0]   rd_q, rd_d;
  logic [OUT_CNT_W-1:0]   cnt_q, cnt_d;
  logic                   do_pop;

  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];
  assign space_o = cnt_q <= OUT_CNT_W'(OUT_DEPTH - 2);
  assign full_o  = cnt_q == OUT_CNT_W'(OUT_DEPTH);
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### sv/eic_datapath.sv
// config registers, crc, header capture and entry parser of the image checker
// depends on eic_pkg; driven by commands from eic_ctrl
`default_nettype none

module eic_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_wr_i,
  input  logic [eic_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [eic_pkg::SIZE_W-1:0]        cfg_data_i,
  input  eic_pkg::in_item_t                 in_data_i,
  input  eic_pkg::dp_cmd_t                  cmd_i,
  output eic_pkg::dp_sts_t                  sts_o,
  output logic                              push_o,
  output eic_pkg::out_item_t                push_data_o
);
  import eic_pkg::*;

  logic [SIZE_W-1:0] img_size_q;
  logic              warn_q;

  logic [SIZE_W-1:0] pos_q, pos_d;
  logic [CRC_W-1:0]  crc_q, crc_d;
  logic [CRC_W-1:0]  hdr_q, hdr_d;
  parse_mode_e       mode_q, mode_d;
  logic [OFS_W-1:0]  beg_q, beg_d;
  logic [OFS_W-1:0]  eqo_q, eqo_d;
  logic              eqf_q, eqf_d;
  logic              over_q, over_d;
  logic              fin_mis_q, fin_mis_d;
  logic              fin_small_q, fin_small_d;

  logic [SIZE_W-1:0] size;
  logic [OFS_W-1:0]  size_sat;
  logic [7:0]        byte_v;
  logic [SIZE_W-1:0] pos_inc;
  logic [CRC_W-1:0]  comp;
  logic              in_range;

  always_comb begin
    size = img_size_q;
    if (img_size_q < SIZE_W'(MIN_IMAGE_BYTES)) begin
      size = SIZE_W'(MIN_IMAGE_BYTES);
    end else if (img_size_q > SIZE_W'(MAX_IMAGE_BYTES)) begin
      size = SIZE_W'(MAX_IMAGE_BYTES);
    end
  end

  assign size_sat = size[SIZE_W-1] ? '1 : size[OFS_W-1:0];
  assign byte_v   = cmd_i.pad ? 8'h00 : in_data_i.data_byte;
  assign pos_inc  = pos_q + 1'b1;
  assign in_range = pos_q < size;
  assign comp     = ~crc_q;

  assign sts_o.too_small  = fin_small_q;
  assign sts_o.pad_left   = in_range;
  assign sts_o.entry_open = mode_q == MODE_ENTRY;

  always_comb begin
    pos_d       = pos_q;
    crc_d       = crc_q;
    hdr_d       = hdr_q;
    mode_d      = mode_q;
    beg_d       = beg_q;
    eqo_d       = eqo_q;
    eqf_d       = eqf_q;
    over_d      = over_q;
    fin_mis_d   = fin_mis_q;
    fin_small_d = fin_small_q;
    push_o      = 1'b0;
    push_data_o = '0;

    if (cmd_i.step || cmd_i.pad) begin
      if (!in_range) begin
        over_d = 1'b1;
      end else begin
        pos_d = pos_inc;
        if (pos_q < SIZE_W'(HDR_BYTES)) begin
          hdr_d = hdr_q | (CRC_W'(byte_v) << {pos_q[1:0], 3'b000});
        end else begin
          crc_d = crc_byte(crc_q, byte_v);
          unique case (mode_q)
            MODE_AWAIT: begin
              if (byte_v == 8'h00) begin
                if (!cmd_i.pad) begin
                  push_o                    = 1'b1;
                  push_data_o.event_kind    = EV_LIST_END;
                  push_data_o.entry_begin   = pos_q[OFS_W-1:0];
                  push_data_o.entry_finish  = pos_q[OFS_W-1:0];
                end
                mode_d = MODE_DONE;
              end else begin
                beg_d  = pos_q[OFS_W-1:0];
                eqf_d  = byte_v == ASCII_EQ;
                eqo_d  = (byte_v == ASCII_EQ) ? pos_q[OFS_W-1:0] : '0;
                mode_d = MODE_ENTRY;
              end
            end
            MODE_ENTRY: begin
              if (byte_v == 8'h00) begin
                push_o = 1'b1;
                if (!eqf_q) begin
                  push_data_o.event_kind = EV_NO_EQ;
                end else if (({1'b0, eqo_q} + 1'b1) == pos_q) begin
                  push_data_o.event_kind = EV_EMPTY;
                end else begin
                  push_data_o.event_kind = EV_OK;
                end
                push_data_o.entry_begin   = beg_q;
                push_data_o.equals_offset = eqo_q;
                push_data_o.entry_finish  = pos_q[OFS_W-1:0];
                mode_d = MODE_AWAIT;
              end else if (byte_v == ASCII_EQ && !eqf_q) begin
                eqf_d = 1'b1;
                eqo_d = pos_q[OFS_W-1:0];
              end
            end
            default: ;
          endcase
          if (mode_d == MODE_ENTRY && pos_inc >= size) begin
            push_o                    = 1'b1;
            push_data_o.event_kind    = EV_UNTERM;
            push_data_o.entry_begin   = beg_d;
            push_data_o.equals_offset = eqo_d;
            push_data_o.entry_finish  = size_sat;
            mode_d = MODE_DONE;
          end
        end
      end
      push_data_o.run_last = cmd_i.step && !in_data_i.final_byte;
      if (cmd_i.step && in_data_i.final_byte) begin
        fin_mis_d   = over_d || (pos_d != size);
        fin_small_d = !over_d && (pos_d < SIZE_W'(MIN_IMAGE_BYTES));
      end
    end

    if (cmd_i.close && mode_q == MODE_ENTRY) begin
      push_o                    = 1'b1;
      push_data_o.event_kind    = EV_UNTERM;
      push_data_o.entry_begin   = beg_q;
      push_data_o.equals_offset = eqo_q;
      push_data_o.entry_finish  = size_sat;
      mode_d = MODE_DONE;
    end

    if (cmd_i.check) begin
      push_o                 = 1'b1;
      push_data_o.event_kind = EV_CHECK;
      push_data_o.stored_crc = hdr_q;
      push_data_o.run_last   = 1'b1;
      if (fin_small_q) begin
        push_data_o.check_status  = CHK_SMALL;
        push_data_o.size_mismatch = 1'b1;
      end else begin
        push_data_o.computed_crc  = comp;
        push_data_o.size_mismatch = fin_mis_q;
        if (comp == hdr_q) begin
          push_data_o.check_status = CHK_OK;
        end else begin
          push_data_o.check_status = warn_q ? CHK_WARN : CHK_FATAL;
        end
      end
      // back to the start of a new image
      pos_d       = '0;
      crc_d       = CRC_INIT;
      hdr_d       = '0;
      mode_d      = MODE_AWAIT;
      beg_d       = OFS_W'(HDR_BYTES);
      eqo_d       = '0;
      eqf_d       = 1'b0;
      over_d      = 1'b0;
      fin_mis_d   = 1'b0;
      fin_small_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_size_q <= SIZE_W'(SIZE_RESET);
      warn_q     <= 1'b0;
    end else if (cfg_wr_i) begin
      unique case (cfg_index_i)
        CFG_IMAGE_SIZE: img_size_q <= cfg_data_i;
        CFG_CRC_WARN:   warn_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      crc_q       <= CRC_INIT;
      hdr_q       <= '0;
      mode_q      <= MODE_AWAIT;
      beg_q       <= OFS_W'(HDR_BYTES);
      eqo_q       <= '0;
      eqf_q       <= 1'b0;
      over_q      <= 1'b0;
      fin_mis_q   <= 1'b0;
      fin_small_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      hdr_q       <= hdr_d;
      mode_q      <= mode_d;
      beg_q       <= beg_d;
      eqo_q       <= eqo_d;
      eqf_q       <= eqf_d;
      over_q      <= over_d;
      fin_mis_q   <= fin_mis_d;
      fin_small_q <= fin_small_d;
    end
  end

endmodule

`default_nettype wire

### sv/eic_ctrl.sv
// sequencer for the image checker: byte intake, zero padding, closing result
// depends on eic_pkg; commands eic_datapath
`default_nettype none

module eic_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              final_i,
  input  logic              space_i,
  input  eic_pkg::dp_sts_t  sts_i,
  output logic              in_stall_o,
  output eic_pkg::dp_cmd_t  cmd_o
);
  import eic_pkg::*;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    cmd_o      = '0;
    unique case (state_q)
      CS_IDLE: begin
        in_stall_o = !space_i;
        cmd_o.step = in_valid_i && space_i;
        if (cmd_o.step && final_i) begin
          state_d = CS_PAD;
        end
      end
      CS_PAD: begin
        priority if (sts_i.too_small) begin
          cmd_o.check = 1'b1;
          state_d     = CS_IDLE;
        end else if (sts_i.pad_left) begin
          cmd_o.pad = 1'b1;
        end else begin
          cmd_o.close = 1'b1;
          state_d     = CS_CHECK;
        end
      end
      CS_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = CS_IDLE;
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### sv/env_image_checker.sv
// env_image_checker: checks an environment image streamed one byte per transfer.
// Input channel in_valid_i/in_stall_o carries data_byte and final_byte; output
// channel out_valid_o/out_stall_i carries one result per transfer; cfg_valid_i/
// cfg_ready_o writes image_size (index 0) and crc_warn_only (index 1).
// Ordinary bytes: one transfer per cycle while the output queue has space; entry
// results enter the output queue in the same cycle as the byte that closes them.
// Final byte: the block then feeds a zero byte for each missing byte up to
// image_size through the crc and parser, then closes any open entry and issues
// the check result; in_stall_o stays high after the final byte until the check
// result is issued (no padding when the image is complete or overlong; a too
// small image skips the padding and closing steps).
// Results wait in a four-entry output queue; in_stall_o rises while fewer than
// two entries are free, so a stalled receiver holds up the input side.
// Reset clears the parser and crc state, empties the queue, sets image_size to
// 16384 and crc_warn_only to 0; no clearing pass is needed.
// Depends on eic_pkg, eic_ctrl, eic_datapath, eic_out_fifo and the assert header.
`default_nettype none
`include "env_image_checker_assert.svh"

module env_image_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  eic_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output eic_pkg::out_item_t            out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [eic_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [eic_pkg::SIZE_W-1:0]    cfg_data_i
);
  import eic_pkg::*;

  dp_cmd_t   cmd;
  dp_sts_t   sts;
  logic      push;
  out_item_t push_data;
  logic      space;
  logic      full;
  logic      pop;
  logic      cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign pop         = out_valid_o && !out_stall_i;

  eic_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .final_i    (in_data_i.final_byte),
    .space_i    (space),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  eic_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_wr_i    (cfg_wr),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .push_o      (push),
    .push_data_o (push_data)
  );

  eic_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .valid_o     (out_valid_o),
    .data_o      (out_data_o),
    .space_o     (space),
    .full_o      (full)
  );

  // result queue never overflows
  `EIC_ASSERT(a_no_overflow, !(push && full && !pop), "result queue overflow")
  // closing command always produces the last result of the image
  `EIC_ASSERT(a_check_pushes, !cmd.check || (push && push_data.run_last), "check lost")
  // after the final byte the input side waits for the closing sequence
  `EIC_ASSERT_NEXT(a_final_busy, cmd.step && in_data_i.final_byte, in_stall_o, "final not held")

endmodule

`default_nettype wire
